// ===== rtl/psw_pkg.sv =====
// Shared types, widths and command/mode codes for the pausable stopwatch.
`default_nettype none

package psw_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int TS_WIDTH    = 32;
  localparam int AMT_WIDTH   = 32;
  localparam int OP_WIDTH    = 4;
  localparam int MODE_WIDTH  = 2;
  localparam int OUT_WIDTH   = 32;

  localparam int IN_FIELDS_W  = OP_WIDTH + TS_WIDTH + AMT_WIDTH;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = MODE_WIDTH + 3 * OUT_WIDTH;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [TS_WIDTH-1:0]    ts_t;
  typedef logic [OP_WIDTH-1:0]    op_t;
  typedef logic [MODE_WIDTH-1:0]  mode_t;

  localparam op_t OP_START      = 4'd0;
  localparam op_t OP_PAUSE      = 4'd1;
  localparam op_t OP_RESUME     = 4'd2;
  localparam op_t OP_STOP       = 4'd3;
  localparam op_t OP_ADD_TIME   = 4'd4;
  localparam op_t OP_ADD_ACTIVE = 4'd5;
  localparam op_t OP_SUB_TIME   = 4'd6;
  localparam op_t OP_SUB_ACTIVE = 4'd7;
  localparam op_t OP_CLEAR      = 4'd8;
  localparam op_t OP_QUERY      = 4'd9;

  localparam mode_t MODE_STOPPED = 2'd0;
  localparam mode_t MODE_STARTED = 2'd1;
  localparam mode_t MODE_PAUSED  = 2'd2;

  typedef struct packed {
    op_t                  opcode;
    ts_t                  timestamp;
    logic [AMT_WIDTH-1:0] amount;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    ts_t   segment_start;
    ts_t   pause_mark;
    cnt_t  elapsed_acc;
    cnt_t  active_acc;
    cnt_t  paused_acc;
  } sw_state_t;

  typedef struct packed {
    mode_t                run_state;
    logic [OUT_WIDTH-1:0] elapsed_total;
    logic [OUT_WIDTH-1:0] active_total;
    logic [OUT_WIDTH-1:0] paused_total;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/psw_core.sv =====
// Next-state and result logic for one stopwatch command.
`default_nettype none

module psw_core
  import psw_pkg::*;
(
  input  cmd_t      cmd,
  input  sw_state_t cur,
  output sw_state_t nxt,
  output result_t   res
);

  cnt_t  run_d;
  cnt_t  pause_d;
  cnt_t  amt;
  cnt_t  open_d;
  cnt_t  e_out;
  cnt_t  a_out;
  cnt_t  p_out;
  ts_t   run_ts;
  ts_t   pause_ts;

  always_comb begin
    run_ts   = cmd.timestamp - cur.segment_start;
    pause_ts = cmd.timestamp - cur.pause_mark;
    run_d    = cnt_t'(run_ts);
    pause_d  = cnt_t'(pause_ts);
    amt      = cnt_t'(cmd.amount);
  end

  always_comb begin
    nxt = cur;
    unique case (cmd.opcode)
      OP_START: begin
        nxt.elapsed_acc   = '0;
        nxt.segment_start = cmd.timestamp;
        nxt.mode          = MODE_STARTED;
      end
      OP_PAUSE: begin
        if (cur.mode == MODE_STARTED) begin
          nxt.active_acc  = cur.active_acc + run_d;
          nxt.elapsed_acc = cur.elapsed_acc + run_d;
          nxt.pause_mark  = cmd.timestamp;
          nxt.mode        = MODE_PAUSED;
        end
      end
      OP_RESUME: begin
        if (cur.mode == MODE_PAUSED) begin
          nxt.paused_acc    = cur.paused_acc + pause_d;
          nxt.elapsed_acc   = cur.elapsed_acc + pause_d;
          nxt.segment_start = cmd.timestamp;
          nxt.mode          = MODE_STARTED;
        end
      end
      OP_STOP: begin
        if (cur.mode == MODE_STARTED) begin
          nxt.active_acc  = cur.active_acc + run_d;
          nxt.elapsed_acc = cur.elapsed_acc + run_d;
        end else if (cur.mode == MODE_PAUSED) begin
          // paused time since the mark counts toward elapsed only
          nxt.elapsed_acc = cur.elapsed_acc + pause_d;
        end
        nxt.mode = MODE_STOPPED;
      end
      OP_ADD_TIME: begin
        nxt.elapsed_acc = cur.elapsed_acc + amt;
      end
      OP_ADD_ACTIVE: begin
        nxt.active_acc  = cur.active_acc + amt;
        nxt.elapsed_acc = cur.elapsed_acc + amt;
      end
      OP_SUB_TIME: begin
        nxt.elapsed_acc = cur.elapsed_acc - amt;
      end
      OP_SUB_ACTIVE: begin
        nxt.active_acc  = cur.active_acc - amt;
        nxt.elapsed_acc = cur.elapsed_acc - amt;
      end
      OP_CLEAR: begin
        // a stop followed by zeroing leaves only the mode to set
        nxt.elapsed_acc = '0;
        nxt.active_acc  = '0;
        nxt.paused_acc  = '0;
        nxt.mode        = MODE_STOPPED;
      end
      default: begin
        // query and unused codes leave the state alone
      end
    endcase
  end

  // bring totals up to the timestamp using the updated marks
  always_comb begin
    open_d = '0;
    e_out  = nxt.elapsed_acc;
    a_out  = nxt.active_acc;
    p_out  = nxt.paused_acc;
    if (nxt.mode == MODE_STARTED) begin
      open_d = cnt_t'(ts_t'(cmd.timestamp - nxt.segment_start));
      e_out  = nxt.elapsed_acc + open_d;
      a_out  = nxt.active_acc + open_d;
    end else if (nxt.mode == MODE_PAUSED) begin
      open_d = cnt_t'(ts_t'(cmd.timestamp - nxt.pause_mark));
      e_out  = nxt.elapsed_acc + open_d;
      p_out  = nxt.paused_acc + open_d;
    end
    res.run_state     = nxt.mode;
    res.elapsed_total = OUT_WIDTH'(e_out);
    res.active_total  = OUT_WIDTH'(a_out);
    res.paused_total  = OUT_WIDTH'(p_out);
  end

endmodule

`default_nettype wire

// ===== rtl/pausable_stopwatch.sv =====
// Top level of the pausable stopwatch: input register, state, result register.
`default_nettype none

// Pausable stopwatch. Each input beat carries an opcode, the current timestamp
// and an amount; each beat yields exactly one output beat with the run state
// and the elapsed, active and paused totals brought up to that timestamp.
// Each command passes the input register and then the result register
// before its output beat goes valid; an output stall can hold it between. One
// command is accepted every cycle as long as the output side keeps taking
// beats; while the output stalls, the block holds at most two commands and
// then drops s_tready. The state update and the result come from one pass of
// subtract/add logic between the two registers.

module pausable_stopwatch
  import psw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [3:0] opcode, [35:4] timestamp, [67:36] amount, rest zero
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [1:0] run_state, [33:2] elapsed_total, [65:34] active_total,
  // [97:66] paused_total, rest zero
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  logic      cmd_valid;
  cmd_t      cmd;
  sw_state_t state;
  sw_state_t state_next;
  result_t   res_next;
  result_t   res;
  logic      advance;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !cmd_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_tready) begin
      cmd_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      cmd.opcode    <= s_tdata[OP_WIDTH-1:0];
      cmd.timestamp <= s_tdata[OP_WIDTH +: TS_WIDTH];
      cmd.amount    <= s_tdata[OP_WIDTH+TS_WIDTH +: AMT_WIDTH];
    end
  end

  psw_core u_core (
    .cmd (cmd),
    .cur (state),
    .nxt (state_next),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode          <= MODE_STOPPED;
      state.segment_start <= '0;
      state.pause_mark    <= '0;
      state.elapsed_acc   <= '0;
      state.active_acc    <= '0;
      state.paused_acc    <= '0;
      m_tvalid            <= 1'b0;
    end else if (advance) begin
      m_tvalid <= cmd_valid;
      if (cmd_valid) begin
        state <= state_next;
      end
    end
    if (advance && cmd_valid) begin
      res <= res_next;
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[MODE_WIDTH-1:0]                   = res.run_state;
    m_tdata[MODE_WIDTH +: OUT_WIDTH]          = res.elapsed_total;
    m_tdata[MODE_WIDTH+OUT_WIDTH +: OUT_WIDTH] = res.active_total;
    m_tdata[MODE_WIDTH+2*OUT_WIDTH +: OUT_WIDTH] = res.paused_total;
  end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the pausable stopwatch: directed, random and backpressure runs.
module tb_top;
  import psw_pkg::*;

  // opcodes outside the defined set act as a query
  localparam op_t OP_SPARE_LO = 4'd10;
  localparam op_t OP_SPARE_HI = 4'd15;
  localparam ts_t TS_MAX = '1;
  localparam int MAX_PRINTED = 40;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  // [3:0] opcode, [35:4] timestamp, [67:36] amount, rest zero
  logic [IN_DATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  // [1:0] run_state, [33:2] elapsed_total, [65:34] active_total,
  // [97:66] paused_total, rest zero
  logic [OUT_DATA_W-1:0] m_tdata;

  pausable_stopwatch DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // stopwatch state as the testbench tracks it
  mode_t sw_mode;
  ts_t   seg_mark;
  ts_t   pause_at;
  cnt_t  elapsed_sum;
  cnt_t  active_sum;
  cnt_t  paused_sum;

  result_t readings_due[$];
  int   error_count;
  int   beat_count;
  bit   idle_off;
  bit   keep_offering;
  int   hold_request;
  ts_t  wall_ticks;

  task automatic flag_error(string msg);
    if (error_count < MAX_PRINTED)
      $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // close the open segment or pause into the totals and go to stopped
  function automatic void close_segment(ts_t ts);
    ts_t d;
    if (sw_mode == MODE_STARTED) begin
      d = ts - seg_mark;
      active_sum  += d;
      elapsed_sum += d;
    end else if (sw_mode == MODE_PAUSED) begin
      d = ts - pause_at;
      elapsed_sum += d;
    end
    sw_mode = MODE_STOPPED;
  endfunction

  function automatic result_t stopwatch_step(op_t op, ts_t ts, cnt_t amt);
    ts_t d;
    result_t r;
    case (op)
      OP_START: begin
        elapsed_sum = '0;
        seg_mark = ts;
        sw_mode = MODE_STARTED;
      end
      OP_PAUSE: if (sw_mode == MODE_STARTED) begin
        d = ts - seg_mark;
        active_sum  += d;
        elapsed_sum += d;
        pause_at = ts;
        sw_mode = MODE_PAUSED;
      end
      OP_RESUME: if (sw_mode == MODE_PAUSED) begin
        d = ts - pause_at;
        paused_sum  += d;
        elapsed_sum += d;
        seg_mark = ts;
        sw_mode = MODE_STARTED;
      end
      OP_STOP: close_segment(ts);
      OP_ADD_TIME: elapsed_sum += amt;
      OP_ADD_ACTIVE: begin
        active_sum  += amt;
        elapsed_sum += amt;
      end
      OP_SUB_TIME: elapsed_sum -= amt;
      OP_SUB_ACTIVE: begin
        active_sum  -= amt;
        elapsed_sum -= amt;
      end
      OP_CLEAR: begin
        close_segment(ts);
        elapsed_sum = '0;
        active_sum  = '0;
        paused_sum  = '0;
      end
      default: ;
    endcase
    r.run_state     = sw_mode;
    r.elapsed_total = elapsed_sum;
    r.active_total  = active_sum;
    r.paused_total  = paused_sum;
    if (sw_mode == MODE_STARTED) begin
      d = ts - seg_mark;
      r.elapsed_total += d;
      r.active_total  += d;
    end else if (sw_mode == MODE_PAUSED) begin
      d = ts - pause_at;
      r.elapsed_total += d;
      r.paused_total  += d;
    end
    return r;
  endfunction

  task automatic rest_sender(int n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  task automatic send_cmd(op_t op, ts_t ts, logic [AMT_WIDTH-1:0] amt);
    result_t want;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, amt, ts, op};
    do @(posedge clk); while (!s_tready);
    want = stopwatch_step(op, ts, amt);
    readings_due.push_back(want);
    if (!idle_off && !keep_offering && $urandom_range(0, 5) == 0)
      rest_sender($urandom_range(1, 11));
  endtask

  task automatic wait_all_back();
    rest_sender(1);
    while (readings_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic ts_t next_stamp();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0)
      wall_ticks -= $urandom_range(1, 500);   // clock runs backwards
    else if (r == 1)
      wall_ticks = $urandom;
    else if (r == 2)
      wall_ticks = TS_MAX - $urandom_range(0, 200);
    else
      wall_ticks += $urandom_range(0, 3000);
    return wall_ticks;
  endfunction

  function automatic logic [AMT_WIDTH-1:0] pick_amount();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 5000);
  endfunction

  // next opcode of a plausible session, given where the stopwatch stands
  function automatic op_t session_op();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (sw_mode == MODE_STOPPED) begin
      if (r < 10) return OP_START;
      if (r < 12) return OP_QUERY;
      if (r < 14) return OP_CLEAR;
      return op_t'($urandom_range(OP_ADD_TIME, OP_SUB_ACTIVE));
    end
    if (r < 4) return (sw_mode == MODE_STARTED) ? OP_PAUSE : OP_RESUME;
    if (r < 6) return OP_STOP;
    if (r < 8) return OP_QUERY;
    if (r < 12) return op_t'($urandom_range(OP_ADD_TIME, OP_SUB_ACTIVE));
    if (r == 12) return OP_START;
    if (r == 13) return OP_CLEAR;
    return (sw_mode == MODE_STARTED) ? OP_RESUME : OP_PAUSE;   // no-op in this mode
  endfunction

  task automatic send_random(int n, int noise_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_cmd(op_t'($urandom_range(0, 15)), $urandom, $urandom);
      else
        send_cmd(session_op(), next_stamp(), pick_amount());
    end
  endtask

  task automatic test_directed();
    send_cmd(OP_QUERY, '0, '0);
    send_cmd(OP_PAUSE, 32'h10, '0);
    send_cmd(OP_RESUME, 32'h20, '0);
    send_cmd(OP_STOP, 32'h30, '0);
    send_cmd(OP_START, 32'hFFFF_FFF0, '0);
    send_cmd(OP_QUERY, 32'h10, '0);            // timestamp wrapped past zero
    send_cmd(OP_RESUME, 32'h18, TS_MAX);       // ignored while started
    send_cmd(OP_PAUSE, 32'h20, '0);
    send_cmd(OP_PAUSE, 32'h28, '0);            // already paused
    send_cmd(OP_QUERY, 32'h5, '0);             // backwards in time
    send_cmd(OP_RESUME, 32'h100, '0);
    send_cmd(OP_START, 32'h200, '0);           // restart keeps active/paused
    send_cmd(OP_PAUSE, 32'h300, '0);
    send_cmd(OP_STOP, 32'h400, '0);            // stop while paused
    send_cmd(OP_ADD_TIME, 32'h400, TS_MAX);
    send_cmd(OP_SUB_TIME, 32'h400, TS_MAX);
    send_cmd(OP_ADD_ACTIVE, TS_MAX, 32'h1);
    send_cmd(OP_SUB_ACTIVE, '0, TS_MAX);       // underflow
    send_cmd(OP_ADD_TIME, '0, '0);
    send_cmd(OP_START, '0, '0);
    send_cmd(OP_STOP, TS_MAX, '0);             // stop while started
    send_cmd(OP_START, 32'h1000, '0);
    send_cmd(OP_CLEAR, 32'h2000, '0);          // clear while running
    send_cmd(OP_SPARE_LO, 32'h3000, 32'h5555_5555);
    send_cmd(OP_SPARE_HI, TS_MAX, TS_MAX);
  endtask

  // receiver holds off long enough that the block fills and stalls its input
  task automatic test_output_hold();
    keep_offering = 1'b1;
    hold_request = 150;
    send_random(40, 10);
    keep_offering = 1'b0;
  endtask

  // sender goes quiet until every result is back, several times over
  task automatic test_drain_between();
    repeat (4) begin
      send_random(30, 10);
      wait_all_back();
    end
  endtask

  task automatic test_random_sessions();
    send_random(1400, 12);
  endtask

  task automatic test_full_rate();
    idle_off = 1'b1;
    send_random(200, 12);
  endtask

  // output side: random stall bursts, plus a long hold on request
  initial begin
    int n;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        m_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else if (!idle_off && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 11);
        m_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      beat_count++;
      if (readings_due.size() == 0) begin
        flag_error($sformatf("output beat %0d with nothing outstanding", beat_count));
      end else begin
        want = readings_due.pop_front();
        got.run_state     = m_tdata[1:0];
        got.elapsed_total = m_tdata[33:2];
        got.active_total  = m_tdata[65:34];
        got.paused_total  = m_tdata[97:66];
        if (got.run_state !== want.run_state)
          flag_error($sformatf("beat %0d run_state %0d, want %0d",
                               beat_count, got.run_state, want.run_state));
        if (got.elapsed_total !== want.elapsed_total)
          flag_error($sformatf("beat %0d elapsed_total %h, want %h",
                               beat_count, got.elapsed_total, want.elapsed_total));
        if (got.active_total !== want.active_total)
          flag_error($sformatf("beat %0d active_total %h, want %h",
                               beat_count, got.active_total, want.active_total));
        if (got.paused_total !== want.paused_total)
          flag_error($sformatf("beat %0d paused_total %h, want %h",
                               beat_count, got.paused_total, want.paused_total));
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    error_count = 0;
    beat_count = 0;
    idle_off = 1'b0;
    keep_offering = 1'b0;
    hold_request = 0;
    wall_ticks = '0;
    sw_mode = MODE_STOPPED;
    seg_mark = '0;
    pause_at = '0;
    elapsed_sum = '0;
    active_sum = '0;
    paused_sum = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_output_hold();
    test_drain_between();
    test_random_sessions();
    test_full_rate();
    wait_all_back();
    repeat (10) @(posedge clk);

    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/psw_pkg.sv
rtl/psw_core.sv
rtl/pausable_stopwatch.sv
test/tb_top.sv
